@@ src/srt_pkg.sv @@
// Package for the shortest-remaining-time scheduler: shared types and constants.
// Used by srt_ctrl, srt_dp and srt_preemptive_scheduler.
package srt_pkg;

  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned DefIdBits     = 8;
  localparam int unsigned ProcW         = 8;
  localparam int unsigned ArrW          = 31;
  localparam int unsigned BurstW        = 16;
  localparam int unsigned TimeW         = 32;

  typedef enum logic [0:0] {
    OpArrive = 1'b0,
    OpDrain  = 1'b1
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input item
    logic step;      // perform one scheduling step
    logic ins_step;  // one shift of the sorted insertion
    logic out_take;  // output register was taken
  } srt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;      // the item has been fully handled
    logic inserting; // insertion in progress
    logic out_full;  // output register holds a result
  } srt_sts_t;

endpackage

@@ src/srt_ctrl.sv @@
// Controller state machine for the scheduler: sequences load, scheduling
// steps and insertion shifts. Depends on srt_pkg.
module srt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             out_stall_i,
  input  srt_pkg::srt_sts_t sts_i,
  output srt_pkg::srt_cmd_t cmd_o
);
  import srt_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StIns  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    in_stall_o       = 1'b1;
    cmd_o.out_take   = sts_i.out_full & ~out_stall_i;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (sts_i.done) begin
          state_d = StIdle;
        end else if (sts_i.inserting) begin
          state_d = StIns;
        end else if (!sts_i.out_full || cmd_o.out_take) begin
          cmd_o.step = 1'b1;
        end
      end
      StIns: begin
        if (sts_i.inserting) begin
          cmd_o.ins_step = 1'b1;
        end else begin
          state_d = StRun;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == StIdle) else $error("load outside idle");
  a_no_step_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.step && cmd_o.ins_step)) else $error("step during insertion");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun && sts_i.done) |=> state_q == StIdle) else $error("no return to idle");
endmodule

@@ src/srt_dp.sv @@
// Datapath for the scheduler: ready store, running slot, clock and output
// register. Depends on srt_pkg; driven by srt_ctrl.
module srt_dp #(
  parameter int unsigned QueueDepth = srt_pkg::DefQueueDepth,
  parameter int unsigned IdBits     = srt_pkg::DefIdBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  srt_pkg::srt_cmd_t           cmd_i,
  output srt_pkg::srt_sts_t           sts_o,
  input  logic                        opcode_i,
  input  logic [srt_pkg::ProcW-1:0]   proc_id_i,
  input  logic [srt_pkg::ArrW-1:0]    arrive_at_i,
  input  logic [srt_pkg::BurstW-1:0]  burst_length_i,
  output logic                        out_valid_o,
  output logic [srt_pkg::ProcW-1:0]   seg_proc_o,
  output logic [srt_pkg::TimeW-1:0]   seg_start_o,
  output logic [srt_pkg::TimeW-1:0]   seg_end_o,
  output logic                        completed_o,
  output logic [srt_pkg::TimeW-1:0]   wait_total_o,
  output logic [srt_pkg::TimeW-1:0]   turnaround_o,
  output logic                        dropped_o,
  output logic                        last_o
);
  import srt_pkg::*;

  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // Store entries: registers, each shifted by its neighbour.
  logic [IdBits-1:0] ids_q [QueueDepth];
  logic [ArrW-1:0]   arr_q [QueueDepth];
  logic [BurstW-1:0] svc_q [QueueDepth];
  logic [BurstW-1:0] rem_q [QueueDepth];
  logic [CntW-1:0]   cnt_q;

  logic              run_v_q;
  logic [IdBits-1:0] run_id_q;
  logic [ArrW-1:0]   run_arr_q;
  logic [BurstW-1:0] run_svc_q, run_rem_q;
  logic [TimeW-1:0]  disp_q, now_q;
  logic              started_q;

  // Captured item.
  logic              has_next_q;
  logic [IdBits-1:0] in_id_q;
  logic [ArrW-1:0]   in_arr_q;
  logic [BurstW-1:0] in_burst_q;
  logic [TimeW-1:0]  next_q;
  logic              done_q;
  logic              fin_q;  // the item is scheduled, only the flush remains

  // Pending insertion: shift down from index ins_i_q while the key is larger.
  logic              ins_q;
  logic [CntW-1:0]   ins_i_q;
  logic [IdBits-1:0] ins_id_q;
  logic [ArrW-1:0]   ins_arr_q;
  logic [BurstW-1:0] ins_svc_q, ins_rem_q;

  // Output register, driving the ports.
  logic              ov_q;
  logic [ProcW-1:0]  o_proc_q;
  logic [TimeW-1:0]  o_start_q, o_end_q, o_wait_q, o_tat_q;
  logic              o_comp_q, o_drop_q, o_last_q;

  // Holding register: a result waits here until the next result or the end
  // of the item shows whether it is the last one.
  logic              h_v_q;
  logic [ProcW-1:0]  h_proc_q;
  logic [TimeW-1:0]  h_start_q, h_end_q, h_wait_q, h_tat_q;
  logic              h_comp_q, h_drop_q;

  assign sts_o.done      = done_q;
  assign sts_o.inserting = ins_q;
  assign sts_o.out_full  = ov_q;

  logic [TimeW-1:0] gap, tat;
  logic             cnt_full, cnt_zero, arr_due, preempt;
  assign gap      = next_q - now_q;
  assign tat      = now_q - {1'b0, run_arr_q};
  assign cnt_full = cnt_q == CntW'(QueueDepth);
  assign cnt_zero = cnt_q == '0;
  assign arr_due  = has_next_q && next_q == now_q;
  assign preempt  = !cnt_zero && rem_q[0] < run_rem_q;

  logic [IdxW-1:0] ins_idx, prev_idx;
  assign ins_idx  = ins_i_q[IdxW-1:0];
  assign prev_idx = IdxW'(ins_i_q - CntW'(1));

  // Result produced by the current scheduling step, if any.
  logic             res_v;
  logic [ProcW-1:0] res_proc;
  logic [TimeW-1:0] res_start, res_wait, res_tat;
  logic             res_comp, res_drop;

  always_comb begin
    res_v     = 1'b0;
    res_proc  = ProcW'(run_id_q);
    res_start = disp_q;
    res_comp  = 1'b0;
    res_wait  = '0;
    res_tat   = '0;
    res_drop  = 1'b0;
    if (!fin_q) begin
      if (arr_due) begin
        if (cnt_full) begin
          res_v     = 1'b1;
          res_proc  = ProcW'(in_id_q);
          res_start = now_q;
          res_drop  = 1'b1;
        end
      end else if (run_v_q && run_rem_q == '0) begin
        res_v    = 1'b1;
        res_comp = 1'b1;
        res_wait = tat - TimeW'(run_svc_q);
        res_tat  = tat;
      end else if (run_v_q && preempt) begin
        res_v = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; run_v_q <= 1'b0; run_id_q <= '0; run_arr_q <= '0;
      run_svc_q <= '0; run_rem_q <= '0; disp_q <= '0; now_q <= '0;
      started_q <= 1'b0; done_q <= 1'b0; fin_q <= 1'b0; ins_q <= 1'b0;
      has_next_q <= 1'b0; next_q <= '0;
    end else begin
      done_q <= cmd_i.step && fin_q;
      if (cmd_i.load) begin
        has_next_q <= opcode_i == OpArrive;
        in_id_q    <= IdBits'(proc_id_i);
        in_arr_q   <= arrive_at_i;
        in_burst_q <= burst_length_i;
        if (opcode_i == OpArrive) begin
          if (!started_q) begin
            now_q     <= {1'b0, arrive_at_i};
            started_q <= 1'b1;
            next_q    <= {1'b0, arrive_at_i};
          end else begin
            next_q <= ({1'b0, arrive_at_i} < now_q) ? now_q : {1'b0, arrive_at_i};
          end
        end
      end else if (cmd_i.ins_step) begin
        if (ins_i_q != '0 && rem_q[prev_idx] > ins_rem_q) begin
          ids_q[ins_idx] <= ids_q[prev_idx];
          arr_q[ins_idx] <= arr_q[prev_idx];
          svc_q[ins_idx] <= svc_q[prev_idx];
          rem_q[ins_idx] <= rem_q[prev_idx];
          ins_i_q <= ins_i_q - CntW'(1);
        end else begin
          ids_q[ins_idx] <= ins_id_q;
          arr_q[ins_idx] <= ins_arr_q;
          svc_q[ins_idx] <= ins_svc_q;
          rem_q[ins_idx] <= ins_rem_q;
          cnt_q <= cnt_q + CntW'(1);
          ins_q <= 1'b0;
        end
      end else if (cmd_i.step) begin
        if (fin_q) begin
          fin_q <= 1'b0;
        end else if (arr_due) begin
          if (!cnt_full) begin
            ins_q <= 1'b1; ins_i_q <= cnt_q; ins_id_q <= in_id_q;
            ins_arr_q <= in_arr_q; ins_svc_q <= in_burst_q; ins_rem_q <= in_burst_q;
          end
          fin_q <= 1'b1;
        end else if (!run_v_q) begin
          if (!cnt_zero) begin
            run_v_q <= 1'b1; run_id_q <= ids_q[0]; run_arr_q <= arr_q[0];
            run_svc_q <= svc_q[0]; run_rem_q <= rem_q[0]; disp_q <= now_q;
            for (int i = 1; i < QueueDepth; i++) begin
              ids_q[i-1] <= ids_q[i]; arr_q[i-1] <= arr_q[i];
              svc_q[i-1] <= svc_q[i]; rem_q[i-1] <= rem_q[i];
            end
            cnt_q <= cnt_q - CntW'(1);
          end else if (has_next_q) begin
            now_q <= next_q;
          end else begin
            started_q <= 1'b0;
            fin_q     <= 1'b1;
          end
        end else if (run_rem_q == '0) begin
          run_v_q <= 1'b0;
        end else if (preempt) begin
          run_id_q <= ids_q[0]; run_arr_q <= arr_q[0];
          run_svc_q <= svc_q[0]; run_rem_q <= rem_q[0]; disp_q <= now_q;
          for (int i = 1; i < QueueDepth; i++) begin
            ids_q[i-1] <= ids_q[i]; arr_q[i-1] <= arr_q[i];
            svc_q[i-1] <= svc_q[i]; rem_q[i-1] <= rem_q[i];
          end
          cnt_q <= cnt_q - CntW'(1);
          ins_q <= 1'b1; ins_i_q <= cnt_q - CntW'(1); ins_id_q <= run_id_q;
          ins_arr_q <= run_arr_q; ins_svc_q <= run_svc_q; ins_rem_q <= run_rem_q;
        end else if (has_next_q && gap <= TimeW'(run_rem_q)) begin
          run_rem_q <= run_rem_q - gap[BurstW-1:0];
          now_q     <= next_q;
        end else begin
          now_q     <= now_q + TimeW'(run_rem_q);
          run_rem_q <= '0;
        end
      end
    end
  end

  // A new result pushes the held one out with last clear; the flush at the
  // end of the item pushes it out with last set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; h_v_q <= 1'b0;
    end else begin
      if (cmd_i.step && (res_v || fin_q) && h_v_q) begin
        ov_q <= 1'b1; o_proc_q <= h_proc_q; o_start_q <= h_start_q;
        o_end_q <= h_end_q; o_comp_q <= h_comp_q; o_wait_q <= h_wait_q;
        o_tat_q <= h_tat_q; o_drop_q <= h_drop_q; o_last_q <= fin_q;
      end else if (cmd_i.out_take) begin
        ov_q <= 1'b0;
      end
      if (cmd_i.step && res_v) begin
        h_v_q <= 1'b1; h_proc_q <= res_proc; h_start_q <= res_start;
        h_end_q <= now_q; h_comp_q <= res_comp; h_wait_q <= res_wait;
        h_tat_q <= res_tat; h_drop_q <= res_drop;
      end else if (cmd_i.step && fin_q) begin
        h_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign seg_proc_o   = o_proc_q;
  assign seg_start_o  = o_start_q;
  assign seg_end_o    = o_end_q;
  assign completed_o  = o_comp_q;
  assign wait_total_o = o_wait_q;
  assign turnaround_o = o_tat_q;
  assign dropped_o    = o_drop_q;
  assign last_o       = o_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth)) else $error("store count overflow");
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_q |-> !cnt_full) else $error("insertion into full store");
  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (started_q && $past(started_q) && !$past(cmd_i.load)) |-> now_q >= $past(now_q))
    else $error("time went backwards");
endmodule

@@ src/srt_preemptive_scheduler.sv @@
// Channel | Handshake           | Payload
// in      | in_valid/in_stall   | opcode, proc_id, arrive_at, burst_length
// out     | out_valid/out_stall | seg_proc .. last
// Steps: a load, then scheduling steps; each insertion into the ready store takes
// up to QUEUE_DEPTH - 1 shifts, and the item closes with a flush step and a return
// to idle. A preemption adds an insertion of its own.
// Reset clears the store count, running slot and clock; entries need no reset.
// While a full output register is stalled, no scheduling step is taken.
// Top level: joins srt_ctrl and srt_dp; depends on srt_pkg.
module srt_preemptive_scheduler #(
  parameter int unsigned QUEUE_DEPTH = srt_pkg::DefQueueDepth,
  parameter int unsigned ID_BITS     = srt_pkg::DefIdBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [srt_pkg::ProcW-1:0]   proc_id_i,
  input  logic [srt_pkg::ArrW-1:0]    arrive_at_i,
  input  logic [srt_pkg::BurstW-1:0]  burst_length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [srt_pkg::ProcW-1:0]   seg_proc_o,
  output logic [srt_pkg::TimeW-1:0]   seg_start_o,
  output logic [srt_pkg::TimeW-1:0]   seg_end_o,
  output logic                        completed_o,
  output logic [srt_pkg::TimeW-1:0]   wait_total_o,
  output logic [srt_pkg::TimeW-1:0]   turnaround_o,
  output logic                        dropped_o,
  output logic                        last_o
);
  import srt_pkg::*;

  srt_cmd_t cmd;
  srt_sts_t sts;
  logic     full_stall;

  // Output is taken from the output register; the controller sees a stalled full register as busy.
  assign full_stall = out_valid_o & out_stall_i;

  srt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_stall_i(full_stall), .sts_i(sts), .cmd_o(cmd)
  );

  srt_dp #(.QueueDepth(QUEUE_DEPTH), .IdBits(ID_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .opcode_i, .proc_id_i, .arrive_at_i, .burst_length_i,
    .out_valid_o, .seg_proc_o, .seg_start_o, .seg_end_o, .completed_o,
    .wait_total_o, .turnaround_o, .dropped_o, .last_o
  );
endmodule
